/* sv/drr_pkg.sv */
package drr_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam int MSG_LEN = 26;

	// "Don't copy account number!"
	localparam logic [7:0] MSG_TEXT [MSG_LEN] = '{
		8'h44, 8'h6F, 8'h6E, 8'h27, 8'h74, 8'h20, 8'h63, 8'h6F, 8'h70, 8'h79,
		8'h20, 8'h61, 8'h63, 8'h63, 8'h6F, 8'h75, 8'h6E, 8'h74, 8'h20, 8'h6E,
		8'h75, 8'h6D, 8'h62, 8'h65, 8'h72, 8'h21
	};

	// message character at a position in the redacted run, spaces past the text
	function automatic logic [7:0] redact_char(input logic [6:0] idx);
		logic [7:0] ch;
		if (idx < 7'(MSG_LEN)) begin
			ch = MSG_TEXT[idx[4:0]];
		end else begin
			ch = CHAR_SPACE;
		end
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
	endfunction

endpackage

/* sv/digit_run_redactor_core.sv */
// release: a byte is released once RUN_LENGTH-1 later bytes of its text have arrived, or at
// once when its text ends; after release it passes the window read register and the output register
// throughput: one item per cycle in and out while neither side stalls; an end-of-text flush drains
// up to RUN_LENGTH items at one per cycle through the memory's single read port, as input flows on
// reset: arst_n clears pointers, run counter and flags; the window memory is not cleared
module digit_run_redactor_core #(
	parameter int RUN_LENGTH = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import drr_pkg::*;

	// window ring: RUN_LENGTH-1 held bytes plus a few released ones in flight
	localparam int AW = $clog2(RUN_LENGTH + 4);

	// pointers carry one extra wrap bit for full/empty
	logic [AW:0]   wr_ptr;
	logic [AW:0]   rel_ptr;
	logic [AW:0]   rd_ptr;
	logic          wr_en;
	logic          fire;
	logic [AW:0]   fire_ptr;
	logic          pend_busy;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [8:0]    rd_data;

	// input side: ring write, digit run tracking, release pointer.
	// a completed first run marks its oldest byte; the whole run is then
	// exactly the next RUN_LENGTH bytes that leave the window, so nothing
	// in the memory is rewritten
	drr_ingress #(
		.RUN_LENGTH(RUN_LENGTH),
		.AW        (AW)
	) u_ingress (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.rd_ptr     (rd_ptr),
		.pend_busy  (pend_busy),
		.wr_en      (wr_en),
		.wr_ptr     (wr_ptr),
		.rel_ptr    (rel_ptr),
		.fire       (fire),
		.fire_ptr   (fire_ptr)
	);

	// each entry keeps the byte and its end-of-text flag, which becomes out_last
	drr_window_mem #(
		.AW   (AW),
		.WIDTH(9)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_ptr[AW-1:0]),
		.wr_data({end_of_text, text_byte}),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// output side: read of released entries, message substitution over the
	// marked run, output register that holds a stalled result until it is taken
	drr_egress #(
		.RUN_LENGTH(RUN_LENGTH),
		.AW        (AW)
	) u_egress (
		.clk      (clk),
		.arst_n   (arst_n),
		.rel_ptr  (rel_ptr),
		.fire     (fire),
		.fire_ptr (fire_ptr),
		.rd_ptr   (rd_ptr),
		.pend_busy(pend_busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_last (out_last)
	);

endmodule

/* sv/drr_window_mem.sv */
module drr_window_mem #(
	parameter int AW    = 5,
	parameter int WIDTH = 9
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [1 << AW];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/drr_ingress.sv */
module drr_ingress #(
	parameter int RUN_LENGTH = 26,
	parameter int AW         = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	input  logic [AW:0] rd_ptr,
	input  logic        pend_busy,
	output logic        wr_en,
	output logic [AW:0] wr_ptr,
	output logic [AW:0] rel_ptr,
	output logic        fire,
	output logic [AW:0] fire_ptr
);
	import drr_pkg::*;

	localparam int RW = $clog2(RUN_LENGTH + 1);
	localparam logic [RW-1:0] RUN_MAX  = RW'(RUN_LENGTH);
	localparam logic [RW-1:0] RUN_LAST = RW'(RUN_LENGTH - 1);
	localparam logic [AW:0]   HOLD_MAX = (AW + 1)'(RUN_LENGTH - 1);

	logic [AW:0]   wr_ptr_q;
	logic [AW:0]   rel_ptr_q;
	logic [RW-1:0] run_q;
	logic          replaced_q;

	logic [AW:0]   used;
	logic [AW:0]   held;
	logic          digit;
	logic [RW-1:0] run_next;
	logic          window_full;
	logic          fire_cand;
	logic          accept;

	assign used        = wr_ptr_q - rd_ptr;
	assign held        = wr_ptr_q - rel_ptr_q;
	assign digit       = is_digit(text_byte);
	assign window_full = (held == HOLD_MAX);

	always_comb begin
		if (!digit) begin
			run_next = '0;
		end else if (run_q == RUN_MAX) begin
			run_next = run_q;
		end else begin
			run_next = run_q + 1'b1;
		end
	end

	// this item completes the first full digit run of the text
	assign fire_cand = digit && (run_q == RUN_LAST) && !replaced_q && window_full;

	// one redaction mark outstanding at a time
	assign in_ready = !used[AW] && !(fire_cand && pend_busy);
	assign accept   = in_valid && in_ready;

	assign wr_en    = accept;
	assign wr_ptr   = wr_ptr_q;
	assign rel_ptr  = rel_ptr_q;
	assign fire     = accept && fire_cand;
	assign fire_ptr = rel_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rel_ptr_q  <= '0;
			run_q      <= '0;
			replaced_q <= 1'b0;
		end else if (accept) begin
			wr_ptr_q <= wr_ptr_q + 1'b1;
			if (end_of_text) begin
				rel_ptr_q  <= wr_ptr_q + 1'b1;
				run_q      <= '0;
				replaced_q <= 1'b0;
			end else begin
				run_q <= run_next;
				if (fire_cand) begin
					replaced_q <= 1'b1;
				end
				if (window_full) begin
					rel_ptr_q <= rel_ptr_q + 1'b1;
				end
			end
		end
	end

endmodule

/* sv/drr_egress.sv */
module drr_egress #(
	parameter int RUN_LENGTH = 26,
	parameter int AW         = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW:0]   rel_ptr,
	input  logic          fire,
	input  logic [AW:0]   fire_ptr,
	output logic [AW:0]   rd_ptr,
	output logic          pend_busy,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [8:0]    rd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import drr_pkg::*;

	localparam int CW = $clog2(RUN_LENGTH);
	localparam logic [CW-1:0] CNT_LAST = CW'(RUN_LENGTH - 1);

	logic [AW:0]   rd_ptr_q;
	logic          valid_s1;
	logic [AW-1:0] ptr_s1;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          pend_q;
	logic [AW-1:0] mark_ptr_q;
	logic          redact_q;
	logic [CW-1:0] rcnt_q;

	logic move;
	logic run_start;

	assign move      = valid_s1 && (!out_valid_q || out_ready);
	assign rd_en     = (rel_ptr != rd_ptr_q) && (!valid_s1 || move);
	assign rd_addr   = rd_ptr_q[AW-1:0];
	assign rd_ptr    = rd_ptr_q;
	assign pend_busy = pend_q;
	assign run_start = pend_q && (ptr_s1 == mark_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			redact_q    <= 1'b0;
			rcnt_q      <= '0;
		end else begin
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				ptr_s1   <= rd_ptr_q[AW-1:0];
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end

			if (fire) begin
				pend_q     <= 1'b1;
				mark_ptr_q <= fire_ptr[AW-1:0];
			end

			if (move) begin
				out_valid_q <= 1'b1;
				out_last_q  <= rd_data[8];
				priority if (run_start) begin
					out_byte_q <= redact_char('0);
					pend_q     <= 1'b0;
					redact_q   <= 1'b1;
					rcnt_q     <= CW'(1);
				end else if (redact_q) begin
					out_byte_q <= redact_char(7'(rcnt_q));
					rcnt_q     <= rcnt_q + 1'b1;
					redact_q   <= (rcnt_q != CNT_LAST);
				end else begin
					out_byte_q <= rd_data[7:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

/* sv/drr_checker.sv */
module drr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] text_byte,
	input logic       end_of_text,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output item changed");

	// leaving reset, nothing is pending at the output
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output item present right after reset");

	// leaving reset, the window has room and no redaction is outstanding
	a_reset_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_ready)
		else $error("input not ready right after reset");

endmodule

bind digit_run_redactor_core drr_checker u_drr_checker (.*);

/* tb/sv/testbench.sv */
module testbench;
	import drr_pkg::*;

	localparam int RUN_LEN = 26;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte   = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	digit_run_redactor_core #(
		.RUN_LENGTH(RUN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	always #5 clk = ~clk;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
		int         gap;
		bit         wait_drain;
	} text_item_t;

	typedef struct {
		logic [7:0] ch;
		logic       last;
	} out_char_t;

	text_item_t pending_items[$];
	out_char_t  expected_chars[$];

	int predicted_total = 0;
	int received_total  = 0;
	int mismatches      = 0;
	int gap_mode        = 0;
	int rx_mode         = 0;

	// shadow of the redaction state
	logic [7:0]  held_chars[RUN_LEN];
	int unsigned held_count = 0;
	int unsigned digit_run  = 0;
	bit          run_redacted = 1'b0;

	// idle cycles before an item: none, any, or occasional
	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 14);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
		endcase
	endfunction

	task automatic push_expected(input logic [7:0] c, input logic last);
		out_char_t oc;
		oc.ch = c;
		oc.last = last;
		expected_chars.push_back(oc);
		predicted_total++;
	endtask

	task automatic predict_redaction(input logic [7:0] c, input logic eot);
		if (held_count < RUN_LEN) begin
			held_chars[held_count] = c;
			held_count++;
		end
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			if (digit_run < RUN_LEN)
				digit_run++;
		end else begin
			digit_run = 0;
		end
		// first full run in this text: window holds exactly the run digits
		if (!run_redacted && digit_run >= RUN_LEN && held_count == RUN_LEN) begin
			for (int i = 0; i < RUN_LEN; i++)
				held_chars[i] = (i < MSG_LEN) ? MSG_TEXT[i] : CHAR_SPACE;
			run_redacted = 1'b1;
		end
		if (eot) begin
			for (int i = 0; i < held_count; i++)
				push_expected(held_chars[i], (i + 1 == held_count));
			held_count = 0;
			digit_run = 0;
			run_redacted = 1'b0;
		end else if (held_count == RUN_LEN) begin
			push_expected(held_chars[0], 1'b0);
			for (int i = 0; i < RUN_LEN - 1; i++)
				held_chars[i] = held_chars[i + 1];
			held_count--;
		end
	endtask

	// text building
	task automatic add_item(input logic [7:0] c);
		text_item_t it;
		it.ch = c;
		it.eot = 1'b0;
		it.gap = draw_wait(gap_mode);
		it.wait_drain = 1'b0;
		pending_items.push_back(it);
	endtask

	task automatic add_digits(input int n);
		for (int i = 0; i < n; i++)
			add_item(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_other(input int n);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom_range(0, 255));
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				c = c ^ 8'h40;
			add_item(c);
		end
	endtask

	task automatic add_noise(input int n);
		for (int i = 0; i < n; i++)
			add_item(8'($urandom_range(0, 255)));
	endtask

	task automatic close_text(input int first, input bit drain);
		pending_items[first].wait_drain = drain;
		pending_items[pending_items.size() - 1].eot = 1'b1;
	endtask

	task automatic run_text(input int lead, input int run, input int trail, input bit drain);
		int first;
		first = pending_items.size();
		gap_mode = $urandom_range(0, 2);
		add_other(lead);
		add_digits(run);
		add_other(trail);
		close_text(first, drain);
	endtask

	function automatic int pick_run();
		case ($urandom_range(0, 6))
			0: return 1;
			1: return 25;
			2: return 26;
			3: return 27;
			4: return 40;
			5: return 52;
			default: return $urandom_range(2, 60);
		endcase
	endfunction

	task automatic random_text(input bit drain);
		int first;
		int kind;
		first = pending_items.size();
		gap_mode = $urandom_range(0, 2);
		kind = $urandom_range(0, 19);
		if (kind < 5) begin
			add_noise($urandom_range(1, 40));
		end else if (kind < 13) begin
			add_other($urandom_range(0, 4));
			add_digits(pick_run());
			add_other($urandom_range(0, 4));
		end else if (kind < 17) begin
			// two runs, only the first is redacted
			add_other($urandom_range(0, 3));
			add_digits($urandom_range(26, 30));
			add_other($urandom_range(1, 3));
			add_digits($urandom_range(26, 28));
			add_other($urandom_range(0, 2));
		end else begin
			// runs one short of the length, split by one other byte
			add_other($urandom_range(0, 2));
			add_digits(RUN_LEN - 1);
			add_other(1);
			add_digits(RUN_LEN - 1);
		end
		close_text(first, drain);
	endtask

	task automatic short_text(input logic [7:0] a, input logic [7:0] b, input int n);
		int first;
		first = pending_items.size();
		gap_mode = $urandom_range(0, 2);
		add_item(a);
		if (n > 1)
			add_item(b);
		close_text(first, 1'b0);
	endtask

	// sender
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		text_item_t nxt;
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
			text_byte <= 8'h00;
			end_of_text <= 1'b0;
			gap_left = 0;
		end else begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				predict_redaction(text_byte, end_of_text);
				offer = 1'b0;
				gap_left = (pending_items.size() != 0) ? pending_items[0].gap : 0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0 &&
						!(pending_items[0].wait_drain && predicted_total != received_total)) begin
					nxt = pending_items.pop_front();
					text_byte <= nxt.ch;
					end_of_text <= nxt.eot;
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// one long hold so the window fills and input backs up
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (!hold_done && received_total == 80) begin
			hold_left <= 500;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver and checker
	int  stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		out_char_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected item: byte %h last %b", out_byte, out_last);
					mismatches++;
				end else begin
					want = expected_chars.pop_front();
					if (out_byte !== want.ch || out_last !== want.last) begin
						if (mismatches < 10)
							$display("item %0d: expected byte %h last %b, got byte %h last %b",
								received_total, want.ch, want.last, out_byte, out_last);
						mismatches++;
					end
				end
				received_total <= received_total + 1;
				if (received_total % 50 == 49)
					rx_mode = $urandom_range(0, 2);
				stall_left = draw_wait(rx_mode);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (hold_left == 0 && stall_left == 0);
		end
	end

	initial begin
		bit late_drain;
		late_drain = 1'b0;

		// short texts: byte extremes, digit boundaries, single-byte text, digit at end
		short_text(8'h00, 8'h00, 1);
		short_text(8'hFF, 8'h00, 1);
		short_text(8'h2F, CHAR_ZERO, 2);
		short_text(CHAR_NINE, 8'h3A, 2);
		short_text(8'h7F, 8'h80, 2);
		short_text(8'h55, 8'hAA, 2);
		short_text(CHAR_ZERO, CHAR_NINE, 2);

		// run completing on the final byte, run then tail, long run past the length
		run_text(2, RUN_LEN, 0, 1'b0);
		run_text(0, RUN_LEN, 5, 1'b1);
		run_text(1, 2 * RUN_LEN, 2, 1'b0);

		while (pending_items.size() < 290) begin
			random_text(!late_drain && pending_items.size() >= 250);
			if (pending_items.size() >= 250)
				late_drain = 1'b1;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || predicted_total != received_total);
		repeat (40) @(negedge clk);

		if (expected_chars.size() != 0) begin
			$display("%0d expected items never arrived", expected_chars.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS digit_run_redactor_core");
		else
			$display("FAIL digit_run_redactor_core");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL digit_run_redactor_core");
		$finish;
	end

endmodule
